// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define IPT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define IPT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/ipt_pkg.sv =====
`timescale 1ns / 1ps

package ipt_pkg;

  // Default geometry
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_COORD_BITS  = 16;
  localparam int DEF_FRAC_BITS   = 16;

  // Fixed field widths
  localparam int SPAN_BITS   = 7;
  localparam int FUNC_BITS   = 2;
  localparam int STATUS_BITS = 2;

  // Request function codes (in_tuser)
  localparam logic [FUNC_BITS-1:0] FUNC_APPEND  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_QRY_ABS = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_QRY_DIF = 2'd3;

  // Result status codes (out_tuser)
  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APP_READ,
    ST_APP_WRITE,
    ST_SCALE,
    ST_INDEX,
    ST_RD_HI,
    ST_MUL_X,
    ST_MUL_Y,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/interpolated_point_table.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Ports                      Contents
// in       in   in_tvalid/tready/tdata     tdata: point_x, point_y, sample, span_count
//                in_tuser                  tuser: func
// out      out  out_tvalid/tready/tdata    tdata: out_x, out_y, entry_count
//                out_tuser                 tuser: status
//
// One request at a time: in_tready is high only while the sequencer is idle.
// A query steps through scale, index, rd_hi, mul_x, mul_y, fin; an append through read, write;
// remove or flagged go straight to out; a new request is taken the cycle after the result is.
// Query cost is set by the one shared multiplier (scale, then x, then y) and the
// single read port of the entry RAM. A stalled result holds until out_tready.
// Reset clears the sequencer and the point count; the entry RAM is not cleared.
module interpolated_point_table #(
  parameter int TABLE_DEPTH = ipt_pkg::DEF_TABLE_DEPTH,
  parameter int COORD_BITS  = ipt_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS   = ipt_pkg::DEF_FRAC_BITS,
  localparam int VAL_W      = COORD_BITS + 1,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int SMP_W      = FRAC_BITS + 1,
  localparam int IN_W       = 2 * COORD_BITS + SMP_W + ipt_pkg::SPAN_BITS,
  localparam int IN_TD_W    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W      = 2 * VAL_W + CNT_W,
  localparam int OUT_TD_W   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TD_W-1:0]              in_tdata,   // point_x, point_y, sample, span_count
  input  logic [ipt_pkg::FUNC_BITS-1:0]   in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_TD_W-1:0]             out_tdata,  // out_x, out_y, entry_count
  output logic [ipt_pkg::STATUS_BITS-1:0] out_tuser   // status
);

  localparam int SPAN_W = ipt_pkg::SPAN_BITS;
  localparam int DIF_W  = COORD_BITS + 2;
  localparam int ENT_W  = 2 * COORD_BITS + 2 * VAL_W;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int PROD_W = DIF_W + FRAC_BITS + 1;
  localparam int CMP_W  = (CNT_W > SPAN_W + 1) ? CNT_W : SPAN_W + 1;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // Input unpacking
  logic [COORD_BITS-1:0] in_px, in_py;
  logic [SMP_W-1:0]      in_smp;
  logic [SPAN_W-1:0]     in_span;

  assign in_px   = in_tdata[COORD_BITS-1:0];
  assign in_py   = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_smp  = in_tdata[2*COORD_BITS+SMP_W-1:2*COORD_BITS];
  assign in_span = in_tdata[IN_W-1:2*COORD_BITS+SMP_W];

  // Registers
  ipt_pkg::state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [ipt_pkg::FUNC_BITS-1:0]    func_r, func_nxt;
  logic [COORD_BITS-1:0]            px_r, px_nxt, py_r, py_nxt;
  logic [SMP_W-1:0]                 smp_r, smp_nxt;
  logic [SPAN_W-1:0]                span_r, span_nxt;
  logic [ipt_pkg::STATUS_BITS-1:0]  status_r, status_nxt;
  logic signed [PROD_W-1:0]         prod_r, prod_nxt;
  logic [IDX_W-1:0]                 hi_r, hi_nxt;
  logic [FRAC_BITS-1:0]             f_r, f_nxt;
  logic signed [VAL_W-1:0]          ax_r, ax_nxt, ay_r, ay_nxt, by_r, by_nxt;
  logic [VAL_W-1:0]                 resx_r, resx_nxt, resy_r, resy_nxt;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  ipt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry fields from the read port; absolute values widened to table width
  logic signed [VAL_W-1:0] rd_abs_x, rd_abs_y, rd_x, rd_y;
  logic                    sel_abs;

  assign rd_abs_x = $signed({ram_rdata[COORD_BITS-1], ram_rdata[COORD_BITS-1:0]});
  assign rd_abs_y = $signed({ram_rdata[2*COORD_BITS-1], ram_rdata[2*COORD_BITS-1:COORD_BITS]});
  assign sel_abs  = (func_r == ipt_pkg::FUNC_QRY_ABS);
  assign rd_x     = sel_abs ? rd_abs_x
                            : $signed(ram_rdata[2*COORD_BITS+VAL_W-1:2*COORD_BITS]);
  assign rd_y     = sel_abs ? rd_abs_y : $signed(ram_rdata[ENT_W-1:2*COORD_BITS+VAL_W]);

  // Shared multiplier: signed operand times unsigned fraction
  logic signed [DIF_W-1:0]  mul_a;
  logic [FRAC_BITS-1:0]     mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // Round half up, then add the floor entry
  logic signed [PROD_W-1:0] rnd_sum, rnd_shr;
  logic signed [DIF_W-1:0]  lerp_base, lerp_sum;

  assign rnd_sum  = prod_r + $signed(HALF);
  assign rnd_shr  = rnd_sum >>> FRAC_BITS;
  assign lerp_sum = lerp_base + rnd_shr[DIF_W-1:0];

  // Index generation from the scaled sample
  logic [SPAN_W-1:0]    whole;
  logic [FRAC_BITS-1:0] frac;
  logic [CNT_W-1:0]     last;
  logic [CMP_W-1:0]     whole_e, hi_e, last_e, lo_c, hi_c;

  assign whole   = prod_r[FRAC_BITS+SPAN_W-1:FRAC_BITS];
  assign frac    = prod_r[FRAC_BITS-1:0];
  assign last    = count_r - CNT_W'(1);
  assign whole_e = CMP_W'(whole);
  assign hi_e    = whole_e + CMP_W'(frac != '0);
  assign last_e  = CMP_W'(last);
  assign lo_c    = (whole_e > last_e) ? last_e : whole_e;
  assign hi_c    = (hi_e > last_e) ? last_e : hi_e;

  // Append: difference from the previous point, or the point itself when first
  logic signed [VAL_W-1:0] prev_x, prev_y, dif_x, dif_y;

  assign prev_x = (count_r == '0) ? '0 : rd_abs_x;
  assign prev_y = (count_r == '0) ? '0 : rd_abs_y;
  assign dif_x  = $signed({px_r[COORD_BITS-1], px_r}) - prev_x;
  assign dif_y  = $signed({py_r[COORD_BITS-1], py_r}) - prev_y;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    func_nxt   = func_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    smp_nxt    = smp_r;
    span_nxt   = span_r;
    status_nxt = status_r;
    prod_nxt   = prod_r;
    hi_nxt     = hi_r;
    f_nxt      = f_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    by_nxt     = by_r;
    resx_nxt   = resx_r;
    resy_nxt   = resy_r;
    ram_we     = 1'b0;
    ram_waddr  = count_r[IDX_W-1:0];
    ram_wdata  = {dif_y, dif_x, py_r, px_r};
    ram_raddr  = hi_r;
    mul_a      = $signed(DIF_W'(span_r));
    mul_b      = smp_r[FRAC_BITS-1:0];
    lerp_base  = $signed({ax_r[VAL_W-1], ax_r});
    in_tready  = 1'b0;
    out_tvalid = 1'b0;

    unique case (state_r)
      ipt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt   = in_tuser;
          px_nxt     = in_px;
          py_nxt     = in_py;
          smp_nxt    = in_smp;
          span_nxt   = in_span;
          status_nxt = ipt_pkg::STATUS_OK;
          resx_nxt   = '0;
          resy_nxt   = '0;
          unique case (in_tuser)
            ipt_pkg::FUNC_APPEND: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                status_nxt = ipt_pkg::STATUS_FULL;
                state_nxt  = ipt_pkg::ST_OUT;
              end else begin
                state_nxt = ipt_pkg::ST_APP_READ;
              end
            end
            ipt_pkg::FUNC_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ipt_pkg::STATUS_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
              state_nxt = ipt_pkg::ST_OUT;
            end
            ipt_pkg::FUNC_QRY_ABS, ipt_pkg::FUNC_QRY_DIF: begin
              if (count_r == '0) begin
                status_nxt = ipt_pkg::STATUS_EMPTY;
                state_nxt  = ipt_pkg::ST_OUT;
              end else begin
                state_nxt = ipt_pkg::ST_SCALE;
              end
            end
            default: state_nxt = ipt_pkg::ST_OUT;
          endcase
        end
      end

      // Fetch the previous point
      ipt_pkg::ST_APP_READ: begin
        ram_raddr = last[IDX_W-1:0];
        state_nxt = ipt_pkg::ST_APP_WRITE;
      end

      // Store point and difference, bump the count
      ipt_pkg::ST_APP_WRITE: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ipt_pkg::ST_OUT;
      end

      // sample * span_count
      ipt_pkg::ST_SCALE: begin
        prod_nxt  = mul_p;
        state_nxt = ipt_pkg::ST_INDEX;
      end

      // Floor/ceiling indices, clamped (both the last entry when sample bit 16 is set); read the floor entry
      ipt_pkg::ST_INDEX: begin
        if (smp_r[FRAC_BITS]) begin
          ram_raddr = last[IDX_W-1:0];
          hi_nxt    = last[IDX_W-1:0];
          f_nxt     = '0;
        end else begin
          ram_raddr = lo_c[IDX_W-1:0];
          hi_nxt    = hi_c[IDX_W-1:0];
          f_nxt     = frac;
        end
        state_nxt = ipt_pkg::ST_RD_HI;
      end

      // Floor entry arrives; read the ceiling entry
      ipt_pkg::ST_RD_HI: begin
        ax_nxt    = rd_x;
        ay_nxt    = rd_y;
        state_nxt = ipt_pkg::ST_MUL_X;
      end

      // (b - a) * f for x
      ipt_pkg::ST_MUL_X: begin
        mul_a     = $signed({rd_x[VAL_W-1], rd_x}) - $signed({ax_r[VAL_W-1], ax_r});
        mul_b     = f_r;
        prod_nxt  = mul_p;
        by_nxt    = rd_y;
        state_nxt = ipt_pkg::ST_MUL_Y;
      end

      // Finish x; (b - a) * f for y
      ipt_pkg::ST_MUL_Y: begin
        resx_nxt  = lerp_sum[VAL_W-1:0];
        mul_a     = $signed({by_r[VAL_W-1], by_r}) - $signed({ay_r[VAL_W-1], ay_r});
        mul_b     = f_r;
        prod_nxt  = mul_p;
        state_nxt = ipt_pkg::ST_FIN;
      end

      // Finish y
      ipt_pkg::ST_FIN: begin
        lerp_base = $signed({ay_r[VAL_W-1], ay_r});
        resy_nxt  = lerp_sum[VAL_W-1:0];
        state_nxt = ipt_pkg::ST_OUT;
      end

      // Hold the result until taken
      ipt_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ipt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ipt_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipt_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    smp_r    <= smp_nxt;
    span_r   <= span_nxt;
    status_r <= status_nxt;
    prod_r   <= prod_nxt;
    hi_r     <= hi_nxt;
    f_r      <= f_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    by_r     <= by_nxt;
    resx_r   <= resx_nxt;
    resy_r   <= resy_nxt;
  end

  assign out_tdata = OUT_TD_W'({count_r, resy_r, resx_r});
  assign out_tuser = status_r;

endmodule

// ===== rtl/core/ipt_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module ipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ipt_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks for the point table.
module ipt_checker #(
  parameter int TABLE_DEPTH = ipt_pkg::DEF_TABLE_DEPTH,
  parameter int COORD_BITS  = ipt_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS   = ipt_pkg::DEF_FRAC_BITS,
  localparam int VAL_W      = COORD_BITS + 1,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int SMP_W      = FRAC_BITS + 1,
  localparam int OUT_W      = 2 * VAL_W + CNT_W,
  localparam int OUT_TD_W   = ((OUT_W + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [OUT_TD_W-1:0]             out_tdata,
  input logic [ipt_pkg::STATUS_BITS-1:0] out_tuser
);

  logic             flagged;
  logic [CNT_W-1:0] entries;

  assign flagged = (out_tuser != ipt_pkg::STATUS_OK);
  assign entries = out_tdata[OUT_W-1:2*VAL_W];

  // Stalled result holds
  `IPT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // One request in flight: no intake while a result is pending
  `IPT_NEVER(a_one_req, in_tready && out_tvalid, "request taken while a result waits")

  // Accepted request takes the block busy
  `IPT_ASSERT(a_busy, in_tvalid && in_tready |=> !in_tready, "ready stayed high after a request")

  // Count never exceeds the table depth
  `IPT_ASSERT(a_count, out_tvalid |-> entries <= CNT_W'(TABLE_DEPTH), "entry count past depth")

  // Flagged results carry zero coordinates
  `IPT_ASSERT(a_flag_zero, out_tvalid && flagged |-> out_tdata[2*VAL_W-1:0] == '0, "flagged result has coordinates")

endmodule

bind interpolated_point_table ipt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .COORD_BITS  (COORD_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_ipt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/interpolated_point_table_tb.sv =====
`timescale 1ns / 1ps

module interpolated_point_table_tb;
  import ipt_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int IN_TD_W     = 56;
  localparam int OUT_TD_W    = 48;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [1:0]         status;
    logic [6:0]         count;
  } point_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_TD_W-1:0] out_tdata;
  logic [1:0]          out_tuser;

  interpolated_point_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Shadow copy of the point stack
  longint      abs_x [DEPTH];
  longint      abs_y [DEPTH];
  longint      dif_x [DEPTH];
  longint      dif_y [DEPTH];
  int unsigned n_points;

  point_result_t pending_results[$];

  int  mismatch_count;
  int  request_count;
  int  query_count;
  int  full_hits;
  int  empty_hits;
  int  result_count;
  int  cycle_count;
  bit  src_idle_on;
  bit  sink_idle_on;
  int  hold_request;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Round-half-up interpolation between two entries, f in Q0.16
  function automatic longint interp(longint a, longint b, longint f);
    longint p;
    p = (b - a) * f + 64'sd32768;
    return a + (p >>> 16);
  endfunction

  // Applies one request to the shadow stack and returns the expected result
  function automatic point_result_t apply_request(logic [1:0] func, logic signed [15:0] px,
                                                  logic signed [15:0] py, logic [16:0] sample,
                                                  logic [6:0] span);
    point_result_t r;
    longint        rx;
    longint        ry;
    longint        t;
    longint        whole;
    longint        f;
    longint        hi;
    int unsigned   last;
    int unsigned   lo_i;
    int unsigned   hi_i;
    rx = 0;
    ry = 0;
    r.status = STATUS_OK;
    case (func)
      FUNC_APPEND: begin
        if (n_points >= DEPTH) begin
          r.status = STATUS_FULL;
          full_hits++;
        end else begin
          abs_x[n_points] = px;
          abs_y[n_points] = py;
          if (n_points == 0) begin
            dif_x[0] = px;
            dif_y[0] = py;
          end else begin
            dif_x[n_points] = longint'(px) - abs_x[n_points-1];
            dif_y[n_points] = longint'(py) - abs_y[n_points-1];
          end
          n_points++;
        end
      end
      FUNC_REMOVE: begin
        if (n_points == 0) begin
          r.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          n_points--;
        end
      end
      default: begin
        query_count++;
        if (n_points == 0) begin
          r.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          last = n_points - 1;
          if (sample[16]) begin
            lo_i = last;
            hi_i = last;
            f = 0;
          end else begin
            t = longint'(sample) * longint'(span);
            whole = t >> 16;
            f = t & 64'hFFFF;
            hi = whole + ((f != 0) ? 1 : 0);
            lo_i = (whole > last) ? last : int'(whole);
            hi_i = (hi > last) ? last : int'(hi);
          end
          if (func == FUNC_QRY_ABS) begin
            rx = interp(abs_x[lo_i], abs_x[hi_i], f);
            ry = interp(abs_y[lo_i], abs_y[hi_i], f);
          end else begin
            rx = interp(dif_x[lo_i], dif_x[hi_i], f);
            ry = interp(dif_y[lo_i], dif_y[hi_i], f);
          end
        end
      end
    endcase
    r.x = rx[16:0];
    r.y = ry[16:0];
    r.count = n_points[6:0];
    return r;
  endfunction

  // Offers one request and waits for the handshake
  task automatic send_request(logic [1:0] func, logic [15:0] px, logic [15:0] py,
                              logic [16:0] sample, logic [6:0] span);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {span, sample, py, px};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(func, px, py, sample, span));
    request_count++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_query(logic [1:0] func, logic [16:0] sample, logic [6:0] span);
    send_request(func, 16'($urandom), 16'($urandom), sample, span);
  endtask

  task automatic send_append(logic [15:0] px, logic [15:0] py);
    send_request(FUNC_APPEND, px, py, 17'($urandom), 7'($urandom));
  endtask

  // Flagged cases on an empty table, then a single-entry table
  task automatic test_empty_table();
    send_request(FUNC_REMOVE, 16'($urandom), 16'($urandom), 17'($urandom), 7'($urandom));
    send_query(FUNC_QRY_ABS, 17'd0, 7'd0);
    send_query(FUNC_QRY_DIF, 17'h1FFFF, 7'h7F);
    send_append(16'h7FFF, 16'h8000);
    send_query(FUNC_QRY_ABS, 17'h0FFFF, 7'h7F);
    send_query(FUNC_QRY_DIF, 17'h10000, 7'd3);
    send_request(FUNC_REMOVE, 16'h0, 16'h0, 17'h0, 7'h0);
    send_request(FUNC_REMOVE, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 7'h7F);
  endtask

  // Fill with extreme steps, then overflow once
  task automatic test_fill_to_full();
    send_append(16'h8000, 16'h7FFF);
    send_append(16'h7FFF, 16'h8000);
    send_append(16'hFFFF, 16'h0000);
    while (n_points < DEPTH) send_append(16'($urandom), 16'($urandom));
    send_append(16'h1234, 16'h5678);
  endtask

  // Queries on the full table: ends, clamping, half-way rounding
  task automatic test_query_extremes();
    send_query(FUNC_QRY_ABS, 17'd0, 7'd0);
    send_query(FUNC_QRY_ABS, 17'h08000, 7'd1);
    send_query(FUNC_QRY_DIF, 17'h08000, 7'd3);
    send_query(FUNC_QRY_ABS, 17'h0FFFF, 7'd64);
    send_query(FUNC_QRY_DIF, 17'h0FFFF, 7'h7F);
    send_query(FUNC_QRY_ABS, 17'h10000, 7'd0);
    send_query(FUNC_QRY_DIF, 17'h1FFFF, 7'h7F);
    send_query(FUNC_QRY_DIF, 17'h00001, 7'd2);
  endtask

  // Receiver holds off for a long stretch while the bench keeps offering queries
  task automatic test_long_stall();
    hold_request = 300;
    repeat (12) send_query(($urandom_range(0, 1) != 0) ? FUNC_QRY_ABS : FUNC_QRY_DIF,
                           17'($urandom_range(0, 65535)), 7'($urandom_range(0, 64)));
  endtask

  // Random traffic that sweeps the stack between empty and full
  task automatic test_random_traffic(int n);
    bit          growing;
    int unsigned r;
    logic [16:0] sample;
    logic [6:0]  span;
    growing = 1'b1;
    repeat (n) begin
      if (n_points >= DEPTH) growing = 1'b0;
      else if (n_points == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        r = $urandom_range(0, 99);
        if (r < 80) sample = 17'($urandom_range(0, 65535));
        else if (r < 92) sample = 17'($urandom_range(65536, 131071));
        else sample = (r < 96) ? 17'd0 : 17'h0FFFF;
        span = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, n_points))
                                          : 7'($urandom_range(0, 127));
        send_query(($urandom_range(0, 1) != 0) ? FUNC_QRY_ABS : FUNC_QRY_DIF, sample, span);
      end else if ((r < 82) == growing) begin
        send_append(16'($urandom), 16'($urandom));
      end else begin
        send_request(FUNC_REMOVE, 16'($urandom), 16'($urandom), 17'($urandom), 7'($urandom));
      end
    end
  endtask

  // Receiver ready: random stall bursts plus a commanded long hold
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    point_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %h", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[16:0] !== exp_r.x) begin
          $error("out_x: expected %0d, actual %0d", exp_r.x, $signed(out_tdata[16:0]));
          mismatch_count++;
        end
        if (out_tdata[33:17] !== exp_r.y) begin
          $error("out_y: expected %0d, actual %0d", exp_r.y, $signed(out_tdata[33:17]));
          mismatch_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[40:34] !== exp_r.count) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.count, out_tdata[40:34]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_APPEND;
    n_points = 0;
    mismatch_count = 0;
    request_count = 0;
    query_count = 0;
    full_hits = 0;
    empty_hits = 0;
    result_count = 0;
    cycle_count = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    hold_request = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_fill_to_full();
    test_query_extremes();
    test_long_stall();
    test_random_traffic(700);
    // closing stretch at full rate
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random_traffic(150);
    stop_sending();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests (%0d queries), %0d results checked, %0d full and %0d empty flags",
             request_count, query_count, result_count, full_hits, empty_hits);
    $display("stack swept between empty and full under random stalls and one long hold-off");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
